// ===== hdl/ccu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccu_pkg
// Shared types, codes and helpers for the cell cooling energy update pipeline.
// ----------------------------------------------------------------------------
package ccu_pkg;

   // width of the signed working word in the late pipeline stages
   localparam int WIDE = 66;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_BAD_DENSITY = 2'd1,
      ST_KE_HIGH     = 2'd2,
      ST_TEMP_LOW    = 2'd3
   } status_type;

   // configuration register indexes
   localparam logic CSR_FLOOR_TEMP = 1'b0;
   localparam logic CSR_TIME_STEP  = 1'b1;

   // magnitude of a signed 32-bit word; the most negative value maps to 2^31
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? 32'(-v) : 32'(v);
      return r;
   endfunction

   // clip a wide signed value to the signed 32-bit range
   function automatic logic [31:0] sat32(input logic signed [WIDE-1:0] v);
      logic [31:0] r;
      if (!v[WIDE-1] && (|v[WIDE-2:31])) begin
         r = 32'h7FFF_FFFF;
      end else if (v[WIDE-1] && !(&v[WIDE-2:31])) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/ccu_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccu_div
// Pipelined restoring divider: one quotient bit per stage, overflow flag when
// the quotient does not fit Q_W bits, side data carried alongside.
// ----------------------------------------------------------------------------
module ccu_div #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 32,
   parameter int Q_W   = 26,
   parameter int TAG_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_quot,
   output logic             out_ovf,
   output logic [TAG_W-1:0] out_tag
);

   localparam int HI_W  = NUM_W - Q_W;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic             vld_ff [Q_W+1];
   logic [DEN_W-1:0] rem_ff [Q_W+1];
   logic [Q_W-1:0]   low_ff [Q_W+1];
   logic [Q_W-1:0]   quo_ff [Q_W+1];
   logic [DEN_W-1:0] den_ff [Q_W+1];
   logic             ovf_ff [Q_W+1];
   logic [TAG_W-1:0] tag_ff [Q_W+1];

   logic ovf_in;

   // quotient overflows when the upper numerator part already reaches den
   assign ovf_in = CMP_W'(in_num[NUM_W-1:Q_W]) >= CMP_W'(in_den);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      rem_ff[0] <= DEN_W'(in_num[NUM_W-1:Q_W]);
      low_ff[0] <= in_num[Q_W-1:0];
      quo_ff[0] <= '0;
      den_ff[0] <= in_den;
      ovf_ff[0] <= ovf_in;
      tag_ff[0] <= in_tag;
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             take;
      logic [DEN_W-1:0] rem_in;
      logic [Q_W-1:0]   quo_in;

      assign trial  = {rem_ff[k], low_ff[k][Q_W-1-k]};
      assign diff   = trial - {1'b0, den_ff[k]};
      assign take   = trial >= {1'b0, den_ff[k]};
      assign rem_in = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      assign quo_in = {quo_ff[k][Q_W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         rem_ff[k+1] <= rem_in;
         low_ff[k+1] <= low_ff[k];
         quo_ff[k+1] <= quo_in;
         den_ff[k+1] <= den_ff[k];
         ovf_ff[k+1] <= ovf_ff[k];
         tag_ff[k+1] <= tag_ff[k];
      end
   end

   assign out_valid = vld_ff[Q_W];
   assign out_quot  = quo_ff[Q_W];
   assign out_ovf   = ovf_ff[Q_W];
   assign out_tag   = tag_ff[Q_W];

endmodule

// ===== hdl/cell_cooling_energy_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_cooling_energy_update
// Per-cell kinetic/thermal energy split, temperature, radiative cooling and
// thermal energy floor, in signed fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+---------------------
//   request | start, busy, req_*                      | start && !busy
//   result  | rsp_valid, rsp_*                        | one-cycle strobe
//   config  | csr_valid, csr_ready, csr_index, csr_*  | csr_valid && csr_ready
//
// One cell enters per clock while busy is low. The pipeline holds three
// bit-per-stage dividers: kinetic energy (FRAC_BITS+10 stages), temperature
// (FRAC_BITS+33 stages) and cooling loss (33 stages), each behind its own
// input register, plus the nine input, multiply and clamp stages around
// them.
// Reset is synchronous; it clears every valid bit and the config registers,
// and busy is high for the cycle after reset. The result side cannot stall,
// so busy never rises once reset is gone.
// ----------------------------------------------------------------------------
module cell_cooling_energy_update
   import ccu_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_density,
   input  logic signed [31:0] req_mom_x,
   input  logic signed [31:0] req_mom_y,
   input  logic signed [31:0] req_mom_z,
   input  logic signed [31:0] req_total_energy,
   // result
   output logic               rsp_valid,
   output logic signed [31:0] rsp_new_energy,
   output logic signed [31:0] rsp_cell_temp,
   output logic [1:0]         rsp_status,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [31:0]        csr_wdata
);

   // derived widths
   localparam int KE_W  = FRAC_BITS + 10;                  // kinetic energy quotient
   localparam int TE_W  = ((KE_W > 32) ? KE_W : 32) + 2;   // signed thermal energy
   localparam int MAG_W = TE_W - 1;                        // |thermal energy|
   localparam int N2_W  = MAG_W + FRAC_BITS + 1;           // temperature numerator
   localparam int Q2_W  = N2_W - 1;                        // temperature quotient
   localparam int XW    = 93 - FRAC_BITS;                  // d^2*dt >> FRAC_BITS
   localparam int Q3_W  = 33;                              // cooling loss quotient
   localparam int FL_W  = 63 - FRAC_BITS;                  // energy floor
   localparam logic [KE_W-1:0] KE_LIMIT = KE_W'(64'd1000 << FRAC_BITS);
   localparam logic [Q3_W-1:0] DE_CAP   = {1'b1, 32'd0};

   typedef struct packed {
      logic [30:0]        den;
      logic signed [31:0] energy;
      logic [61:0]        den_sq;
      logic               bad;
   } tag1_type;

   typedef struct packed {
      logic signed [31:0]     energy;
      logic [KE_W-1:0]        ke;
      logic signed [TE_W-1:0] te;
      logic                   te_neg;
      status_type             status;
      logic [XW-1:0]          loss_num;
      logic [FL_W-1:0]        floor_e;
   } tag2_type;

   typedef struct packed {
      logic signed [31:0]     energy;
      logic [KE_W-1:0]        ke;
      logic signed [TE_W-1:0] te;
      status_type             status;
      logic [31:0]            temp;
      logic [FL_W-1:0]        floor_e;
   } tag3_type;

   // ---------------------------------------------------------------- config
   logic        busy_ff;
   logic [30:0] floor_temp_ff;
   logic [30:0] time_step_ff;

   // hold busy for the cycle after reset, then take a word every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         floor_temp_ff <= '0;
         time_step_ff  <= '0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FLOOR_TEMP: floor_temp_ff <= csr_wdata[30:0];
               CSR_TIME_STEP:  time_step_ff  <= csr_wdata[30:0];
               default:        ;
            endcase
         end
      end
   end

   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

   // ---------------------------------------------------------------- stage A
   // register the incoming word
   logic               a_vld_ff;
   logic signed [31:0] a_den_ff, a_mx_ff, a_my_ff, a_mz_ff, a_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start && !busy_ff;
      end
      a_den_ff <= req_density;
      a_mx_ff  <= req_mom_x;
      a_my_ff  <= req_mom_y;
      a_mz_ff  <= req_mom_z;
      a_e_ff   <= req_total_energy;
   end

   // ---------------------------------------------------------------- stage B
   // square the momenta and the density
   logic               b_vld_ff;
   logic [63:0]        b_sqx_ff, b_sqy_ff, b_sqz_ff;
   logic [63:0]        b_sqx_in, b_sqy_in, b_sqz_in;
   logic [61:0]        b_dsq_ff, b_dsq_in;
   logic [30:0]        b_den_ff;
   logic signed [31:0] b_e_ff;
   logic               b_bad_ff, b_bad_in;
   logic [31:0]        mag_x, mag_y, mag_z;

   assign mag_x    = mag32(a_mx_ff);
   assign mag_y    = mag32(a_my_ff);
   assign mag_z    = mag32(a_mz_ff);
   assign b_sqx_in = 64'(mag_x) * 64'(mag_x);
   assign b_sqy_in = 64'(mag_y) * 64'(mag_y);
   assign b_sqz_in = 64'(mag_z) * 64'(mag_z);
   assign b_dsq_in = 62'(a_den_ff[30:0]) * 62'(a_den_ff[30:0]);
   assign b_bad_in = a_den_ff[31] || (a_den_ff == 32'sd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
      b_sqx_ff <= b_sqx_in;
      b_sqy_ff <= b_sqy_in;
      b_sqz_ff <= b_sqz_in;
      b_dsq_ff <= b_dsq_in;
      b_den_ff <= a_den_ff[30:0];
      b_e_ff   <= a_e_ff;
      b_bad_ff <= b_bad_in;
   end

   // ---------------------------------------------------------------- stage C
   // sum |M|^2, form 2d for the kinetic energy divider
   logic        c_vld_ff;
   logic [63:0] c_sum_ff;
   logic [31:0] c_den2_ff;
   tag1_type    c_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
      c_sum_ff        <= b_sqx_ff + b_sqy_ff + b_sqz_ff;
      c_den2_ff       <= {b_den_ff, 1'b0};
      c_tag_ff.den    <= b_den_ff;
      c_tag_ff.energy <= b_e_ff;
      c_tag_ff.den_sq <= b_dsq_ff;
      c_tag_ff.bad    <= b_bad_ff;
   end

   // kinetic energy = |M|^2 / 2d
   logic            k_vld;
   logic [KE_W-1:0] k_quot;
   logic            k_ovf;
   tag1_type        k_tag;

   ccu_div #(
      .NUM_W (64),
      .DEN_W (32),
      .Q_W   (KE_W),
      .TAG_W ($bits(tag1_type))
   ) u_div_ke (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_vld_ff),
      .in_num    (c_sum_ff),
      .in_den    (c_den2_ff),
      .in_tag    (c_tag_ff),
      .out_valid (k_vld),
      .out_quot  (k_quot),
      .out_ovf   (k_ovf),
      .out_tag   (k_tag)
   );

   // ---------------------------------------------------------------- stage D
   // classify, thermal energy, split d^2*dt into two partial products
   logic                   d_vld_ff;
   status_type             d_status_ff, d_status_in;
   logic signed [TE_W-1:0] d_te_ff, d_te_in;
   logic [KE_W-1:0]        d_ke_ff;
   logic signed [31:0]     d_e_ff;
   logic [61:0]            d_plo_ff, d_phi_ff, d_plo_in, d_phi_in;
   logic [32:0]            d_den3_ff, d_den3_in;

   always_comb begin
      if (k_tag.bad) begin
         d_status_in = ST_BAD_DENSITY;
      end else if (k_ovf || (k_quot >= KE_LIMIT)) begin
         d_status_in = ST_KE_HIGH;
      end else begin
         d_status_in = ST_OK;
      end
   end

   assign d_te_in   = TE_W'(k_tag.energy) - $signed(TE_W'(k_quot));
   assign d_plo_in  = 62'(k_tag.den_sq[30:0]) * 62'(time_step_ff);
   assign d_phi_in  = 62'(k_tag.den_sq[61:31]) * 62'(time_step_ff);
   assign d_den3_in = 33'(k_tag.den) + {1'b0, k_tag.den, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= k_vld;
      end
      d_status_ff <= d_status_in;
      d_te_ff     <= d_te_in;
      d_ke_ff     <= k_quot;
      d_e_ff      <= k_tag.energy;
      d_plo_ff    <= d_plo_in;
      d_phi_ff    <= d_phi_in;
      d_den3_ff   <= d_den3_in;
   end

   // ---------------------------------------------------------------- stage E
   // |TE|, cooling numerator, energy floor 1.5*d*floor_temp
   logic             e_vld_ff;
   logic [MAG_W-1:0] e_mag_in;
   logic [N2_W-1:0]  e_num_ff;
   logic [32:0]      e_den3_ff;
   logic [92:0]      e_loss_full;
   logic [63:0]      e_floor_full;
   tag2_type         e_tag_ff;

   assign e_mag_in     = d_te_ff[TE_W-1] ? MAG_W'(-d_te_ff) : MAG_W'(d_te_ff);
   assign e_loss_full  = {d_phi_ff, 31'd0} + 93'(d_plo_ff);
   assign e_floor_full = 64'(d_den3_ff) * 64'(floor_temp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else begin
         e_vld_ff <= d_vld_ff;
      end
      e_num_ff          <= {e_mag_in, {(FRAC_BITS + 1){1'b0}}};
      e_den3_ff         <= d_den3_ff;
      e_tag_ff.energy   <= d_e_ff;
      e_tag_ff.ke       <= d_ke_ff;
      e_tag_ff.te       <= d_te_ff;
      e_tag_ff.te_neg   <= d_te_ff[TE_W-1];
      e_tag_ff.status   <= d_status_ff;
      e_tag_ff.loss_num <= e_loss_full[92:FRAC_BITS];
      e_tag_ff.floor_e  <= e_floor_full[63:FRAC_BITS+1];
   end

   // temperature magnitude = |TE| * 2 / 3d
   logic            t_vld;
   logic [Q2_W-1:0] t_quot;
   logic            t_ovf;
   tag2_type        t_tag;

   ccu_div #(
      .NUM_W (N2_W),
      .DEN_W (33),
      .Q_W   (Q2_W),
      .TAG_W ($bits(tag2_type))
   ) u_div_temp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_vld_ff),
      .in_num    (e_num_ff),
      .in_den    (e_den3_ff),
      .in_tag    (e_tag_ff),
      .out_valid (t_vld),
      .out_quot  (t_quot),
      .out_ovf   (t_ovf),
      .out_tag   (t_tag)
   );

   // ---------------------------------------------------------------- stage F
   // signed temperature, nonpositive check, saturated report value
   logic                   f_vld_ff;
   logic [XW-1:0]          f_loss_ff;
   logic [Q2_W-1:0]        f_t_ff;
   tag3_type               f_tag_ff;
   logic signed [WIDE-1:0] f_t_wide;
   logic                   f_t_pos;
   status_type             f_status_in;
   logic [31:0]            f_temp_in;

   // the temperature divisor is never zero for a valid cell, so t_ovf
   // stays low; fold it in as a nonpositive guard anyway
   assign f_t_wide = t_tag.te_neg ? -$signed(WIDE'(t_quot)) : $signed(WIDE'(t_quot));
   assign f_t_pos  = !t_tag.te_neg && (t_quot != '0) && !t_ovf;

   always_comb begin
      f_status_in = t_tag.status;
      f_temp_in   = 32'd0;
      if (t_tag.status == ST_OK) begin
         f_temp_in = sat32(f_t_wide);
         if (!f_t_pos) begin
            f_status_in = ST_TEMP_LOW;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else begin
         f_vld_ff <= t_vld;
      end
      f_loss_ff        <= t_tag.loss_num;
      f_t_ff           <= t_quot;
      f_tag_ff.energy  <= t_tag.energy;
      f_tag_ff.ke      <= t_tag.ke;
      f_tag_ff.te      <= t_tag.te;
      f_tag_ff.status  <= f_status_in;
      f_tag_ff.temp    <= f_temp_in;
      f_tag_ff.floor_e <= t_tag.floor_e;
   end

   // cooling loss = d^2 * dt / T
   logic            l_vld;
   logic [Q3_W-1:0] l_quot;
   logic            l_ovf;
   tag3_type        l_tag;

   ccu_div #(
      .NUM_W (XW),
      .DEN_W (Q2_W),
      .Q_W   (Q3_W),
      .TAG_W ($bits(tag3_type))
   ) u_div_loss (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_vld_ff),
      .in_num    (f_loss_ff),
      .in_den    (f_t_ff),
      .in_tag    (f_tag_ff),
      .out_valid (l_vld),
      .out_quot  (l_quot),
      .out_ovf   (l_ovf),
      .out_tag   (l_tag)
   );

   // ---------------------------------------------------------------- stage G
   // cap the loss at 2^32 raw units and take it from thermal energy
   logic                   g_vld_ff;
   logic [Q3_W-1:0]        g_loss_in;
   logic signed [WIDE-1:0] g_ten_ff;
   tag3_type               g_tag_ff;

   assign g_loss_in = (l_ovf || (l_quot[32] && (|l_quot[31:0]))) ? DE_CAP : l_quot;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else begin
         g_vld_ff <= l_vld;
      end
      g_ten_ff <= WIDE'(l_tag.te) - $signed(WIDE'(g_loss_in));
      g_tag_ff <= l_tag;
   end

   // ---------------------------------------------------------------- stage H
   // raise thermal energy to the floor
   logic                   h_vld_ff;
   logic signed [WIDE-1:0] h_floor;
   logic signed [WIDE-1:0] h_ten_ff;
   tag3_type               h_tag_ff;

   assign h_floor = $signed(WIDE'(g_tag_ff.floor_e));

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else begin
         h_vld_ff <= g_vld_ff;
      end
      h_ten_ff <= (g_ten_ff < h_floor) ? h_floor : g_ten_ff;
      h_tag_ff <= g_tag_ff;
   end

   // ---------------------------------------------------------------- stage I
   // KE + TE, saturate, pass the input energy through on a flagged cell
   logic                   rsp_valid_ff;
   logic signed [31:0]     rsp_energy_ff;
   logic signed [31:0]     rsp_temp_ff;
   status_type             rsp_status_ff;
   logic signed [WIDE-1:0] i_sum;

   assign i_sum = h_ten_ff + $signed(WIDE'(h_tag_ff.ke));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= h_vld_ff;
      end
      rsp_energy_ff <= (h_tag_ff.status == ST_OK) ? sat32(i_sum) : h_tag_ff.energy;
      rsp_temp_ff   <= h_tag_ff.temp;
      rsp_status_ff <= h_tag_ff.status;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_energy = rsp_energy_ff;
   assign rsp_cell_temp  = rsp_temp_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
